/* sv/tsfu_pkg.sv */
// tsfu_pkg: shared types, constants and command/status structs for the
// taylor series function unit. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsfu_pkg;

   // default parameter values
   localparam int MAX_TERMS_DEF = 32;
   localparam int FRAC_BITS_DEF = 16;

   // term_count register
   localparam int          TC_W     = 6;
   localparam logic [5:0]  TC_RESET = 6'd25;

   // register file
   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic        REG_TERM_COUNT = 1'b0;

   // internal Q31.32 constants
   localparam logic [63:0] ONE_Q32   = 64'h0000_0001_0000_0000;
   localparam logic [63:0] TWO_Q32   = 64'h0000_0002_0000_0000;
   localparam logic [63:0] HALF_Q32  = 64'h0000_0000_8000_0000;
   localparam logic [63:0] IMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] E_Q32     = 64'h0000_0002_B7E1_5163;
   localparam logic [63:0] INV_E_Q32 = 64'h0000_0000_5E2D_58D8;

   // divider geometry
   localparam int DVD_W  = 65;
   localparam int DSR_W  = 35;
   localparam int DCNT_W = 7;

   // ln scaling step counter
   localparam int K_W = 8;

   typedef enum logic [1:0] {
      OP_EXP = 2'd0,
      OP_LN  = 2'd1,
      OP_SIN = 2'd2,
      OP_COS = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_DOMAIN   = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      MB_X,
      MB_INV_E,
      MB_E,
      MB_TERM,
      MB_Y2
   } mul_b_type;

   typedef enum logic [1:0] {
      K_HOLD,
      K_INC,
      K_DEC
   } k_step_type;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DISPATCH,
      S_RED_CHK,
      S_RED_DN_WAIT,
      S_RED_UP_WAIT,
      S_LN_DIV_WAIT,
      S_Y2,
      S_Y2_WAIT,
      S_LDIV,
      S_LDIV_WAIT,
      S_ADD_Q,
      S_ADD_T,
      S_NEXT,
      S_MUL1,
      S_MUL1_WAIT,
      S_DIV1,
      S_DIV1_WAIT,
      S_MUL2,
      S_MUL2_WAIT,
      S_DIV2,
      S_DIV2_WAIT,
      S_LN_FINAL,
      S_ROUND,
      S_DOMAIN
   } ctrl_state_type;

   typedef struct packed {
      logic             load;
      logic             load_shifted;
      logic             mul_start;
      mul_b_type        mul_b;
      logic             mul_sh32;
      logic             mul_wr;
      logic             mul_to_y2;
      k_step_type       k_step;
      logic             div_start;
      logic             div_ln;
      logic             div_wr;
      logic             div_negate;
      logic [DSR_W-1:0] divisor;
      logic             add_term;
      logic             add_quo;
      logic             track_ov;
      logic             ln_final;
      logic             round;
      logic             dom_err;
   } dp_cmd_type;

   typedef struct packed {
      logic x_nonpos;
      logic v_above;
      logic v_below;
      logic mul_busy;
      logic mul_done;
      logic div_busy;
      logic div_done;
   } dp_stat_type;

endpackage

`default_nettype wire

/* sv/tsfu_req_if.sv */
// tsfu_req_if: request channel (opcode and operand word) with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tsfu_req_if;
   logic               valid;
   logic               ready;
   logic [1:0]         opcode;
   logic signed [31:0] operand;

   modport source (output valid, output opcode, output operand, input ready);
   modport sink   (input valid, input opcode, input operand, output ready);
endinterface

`default_nettype wire

/* sv/tsfu_rsp_if.sv */
// tsfu_rsp_if: response channel (value and status word) with valid/ready.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

interface tsfu_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] value;
   logic [1:0]         status;

   modport source (output valid, output value, output status, input ready);
   modport sink   (input valid, input value, input status, output ready);
endinterface

`default_nettype wire

/* sv/taylor_series_function_unit.sv */
// Each term uses the shared multiplier and the shared divider.
// One word is worked on at a time; the next is taken once the prior finishes.
// Synchronous active-high reset: idle, no pending result, term_count = 25.
`timescale 1ns / 1ps
`default_nettype none

module taylor_series_function_unit #(
   parameter int MAX_TERMS = tsfu_pkg::MAX_TERMS_DEF,
   parameter int FRAC_BITS = tsfu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   tsfu_req_if.sink                             req_chan,
   tsfu_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [tsfu_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [tsfu_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [tsfu_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);
   import tsfu_pkg::*;

   logic [TC_W-1:0] tc_ff, tc_in;
   logic            tc_sel;
   dp_cmd_type      cmd;
   dp_stat_type     stat;

   // term_count register
   always_comb begin
      tc_sel     = csr_paddr[2] == REG_TERM_COUNT;
      tc_in      = tc_ff;
      csr_pready = 1'b1;
      if (csr_psel && csr_penable && csr_pwrite && tc_sel) begin
         tc_in = csr_pwdata[TC_W-1:0];
      end
      csr_prdata = tc_sel ? CSR_DATA_W'(tc_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tc_ff <= TC_RESET;
      end else begin
         tc_ff <= tc_in;
      end
   end

   tsfu_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_opcode (req_chan.opcode),
      .req_ready  (req_chan.ready),
      .rsp_ready  (rsp_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .term_count (tc_ff),
      .stat       (stat),
      .cmd        (cmd)
   );

   tsfu_dpath #(.FRAC_BITS(FRAC_BITS)) u_dpath (
      .clock   (clock),
      .reset   (reset),
      .cmd     (cmd),
      .operand (req_chan.operand),
      .stat    (stat),
      .value   (rsp_chan.value),
      .status  (rsp_chan.status)
   );

endmodule

`default_nettype wire

/* sv/tsfu_mul.sv */
// tsfu_mul: multi-cycle 64x64 unsigned multiplier built from four 32x32
// partial products, with truncating right shift and saturation. Uses tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsfu_mul #(
   parameter int FRAC_BITS = tsfu_pkg::FRAC_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        sh32,
   input  wire logic [63:0] a,
   input  wire logic [63:0] b,
   output logic             busy,
   output logic             done,
   output logic [63:0]      res,
   output logic             ovf
);
   import tsfu_pkg::*;

   logic [63:0]  a_ff, a_in, b_ff, b_in;
   logic         sh32_ff, sh32_in;
   logic [2:0]   idx_ff, idx_in;
   logic [63:0]  pp_ff, pp_in;
   logic [1:0]   pw_ff, pw_in;
   logic         ppv_ff, ppv_in;
   logic [127:0] acc_ff, acc_in;
   logic         busy_ff, busy_in, done_ff, done_in;
   logic [31:0]  a_half, b_half;
   logic [127:0] pp_wide, shifted;

   // partial product selection and placement
   always_comb begin
      a_half = idx_ff[1] ? a_ff[63:32] : a_ff[31:0];
      b_half = idx_ff[0] ? b_ff[63:32] : b_ff[31:0];
      case (pw_ff)
         2'd0:    pp_wide = {64'd0, pp_ff};
         2'd1:    pp_wide = {32'd0, pp_ff, 32'd0};
         default: pp_wide = {pp_ff, 64'd0};
      endcase
   end

   // sequencing of partial products and accumulation
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      sh32_in = sh32_ff;
      idx_in  = idx_ff;
      pp_in   = pp_ff;
      pw_in   = pw_ff;
      ppv_in  = 1'b0;
      acc_in  = acc_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         a_in    = a;
         b_in    = b;
         sh32_in = sh32;
         idx_in  = 3'd0;
         acc_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (idx_ff != 3'd4) begin
            pp_in  = 64'(a_half) * 64'(b_half);
            pw_in  = {1'b0, idx_ff[0]} + {1'b0, idx_ff[1]};
            ppv_in = 1'b1;
            idx_in = idx_ff + 3'd1;
         end else begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
         if (ppv_ff) begin
            acc_in = acc_ff + pp_wide;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         ppv_ff  <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         ppv_ff  <= ppv_in;
         idx_ff  <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      sh32_ff <= sh32_in;
      pp_ff   <= pp_in;
      pw_ff   <= pw_in;
      acc_ff  <= acc_in;
   end

   // shift down to the result format, saturate on overflow
   always_comb begin
      shifted = sh32_ff ? (acc_ff >> 32) : (acc_ff >> FRAC_BITS);
      ovf     = |shifted[127:63];
      res     = ovf ? IMAX : shifted[63:0];
   end

   assign busy = busy_ff;
   assign done = done_ff;

endmodule

`default_nettype wire

/* sv/tsfu_div.sv */
// tsfu_div: restoring unsigned divider, one quotient bit per cycle.
// Uses tsfu_pkg for its widths.
`timescale 1ns / 1ps
`default_nettype none

module tsfu_div (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [tsfu_pkg::DVD_W-1:0] dividend,
   input  wire logic [tsfu_pkg::DSR_W-1:0] divisor,
   output logic                            busy,
   output logic                            done,
   output logic [63:0]                     quo
);
   import tsfu_pkg::*;

   logic [DVD_W-1:0]  quo_ff, quo_in;
   logic [DSR_W-1:0]  rem_ff, rem_in, dsr_ff, dsr_in;
   logic [DCNT_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DSR_W:0]    trial, diff;
   logic              ge;

   // one restoring step
   always_comb begin
      trial = {rem_ff, quo_ff[DVD_W-1]};
      diff  = trial - {1'b0, dsr_ff};
      ge    = trial >= {1'b0, dsr_ff};
   end

   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         cnt_in  = DCNT_W'(DVD_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DVD_W-2:0], ge};
         rem_in = ge ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quo  = quo_ff[63:0];

endmodule

`default_nettype wire

/* sv/tsfu_dpath.sv */
// tsfu_dpath: operand, term, sum and result registers with the shared
// multiplier and divider. Uses tsfu_pkg, tsfu_mul and tsfu_div.
`timescale 1ns / 1ps
`default_nettype none

module tsfu_dpath #(
   parameter int FRAC_BITS = tsfu_pkg::FRAC_BITS_DEF
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire tsfu_pkg::dp_cmd_type cmd,
   input  wire logic signed [31:0]   operand,
   output tsfu_pkg::dp_stat_type     stat,
   output logic signed [31:0]        value,
   output logic [1:0]                status
);
   import tsfu_pkg::*;

   localparam int SH = 32 - FRAC_BITS;

   logic signed [31:0]  x_ff, x_in;
   logic [63:0]         term_ff, term_in, sum_ff, sum_in, y2_ff, y2_in;
   logic [K_W-1:0]      k_ff, k_in;
   logic                ov_ff, ov_in;
   logic                mul_neg_ff, mul_neg_in, div_neg_ff, div_neg_in;
   logic [31:0]         value_ff, value_in;
   logic [1:0]          status_ff, status_in;

   logic [63:0]         term_mag, x_ext, x_mag, mul_b, mul_res, mul_s;
   logic                mul_bneg, mul_ovf, mul_busy, mul_done;
   logic                yneg;
   logic [63:0]         num, den, div_quo, quo_s, addend;
   logic [DVD_W-1:0]    dvd;
   logic [DSR_W-1:0]    dsr;
   logic                dneg, div_busy, div_done;
   logic [64:0]         add_ext;
   logic                sat_pos, sat_neg;
   logic [63:0]         sum_mag, rr;
   logic                clamp;

   // operand magnitudes and multiplier operand select
   always_comb begin
      term_mag = term_ff[63] ? (64'd0 - term_ff) : term_ff;
      x_ext    = {{32{x_ff[31]}}, x_ff};
      x_mag    = x_ff[31] ? (64'd0 - x_ext) : x_ext;
      case (cmd.mul_b)
         MB_X: begin
            mul_b    = x_mag;
            mul_bneg = x_ff[31];
         end
         MB_INV_E: begin
            mul_b    = INV_E_Q32;
            mul_bneg = 1'b0;
         end
         MB_E: begin
            mul_b    = E_Q32;
            mul_bneg = 1'b0;
         end
         MB_TERM: begin
            mul_b    = term_mag;
            mul_bneg = term_ff[63];
         end
         MB_Y2: begin
            mul_b    = y2_ff;
            mul_bneg = 1'b0;
         end
         default: begin
            mul_b    = '0;
            mul_bneg = 1'b0;
         end
      endcase
   end

   // divider operand select: ln quotient y or small-integer divide
   always_comb begin
      yneg = term_ff < ONE_Q32;
      num  = yneg ? (ONE_Q32 - term_ff) : (term_ff - ONE_Q32);
      den  = term_ff + ONE_Q32;
      if (cmd.div_ln) begin
         dvd  = {num[32:0], 32'd0};
         dsr  = den[DSR_W-1:0];
         dneg = yneg;
      end else begin
         dvd  = {1'b0, term_mag};
         dsr  = cmd.divisor;
         dneg = term_ff[63];
      end
   end

   tsfu_mul #(.FRAC_BITS(FRAC_BITS)) u_mul (
      .clock (clock),
      .reset (reset),
      .start (cmd.mul_start),
      .sh32  (cmd.mul_sh32),
      .a     (term_mag),
      .b     (mul_b),
      .busy  (mul_busy),
      .done  (mul_done),
      .res   (mul_res),
      .ovf   (mul_ovf)
   );

   tsfu_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dvd),
      .divisor  (dsr),
      .busy     (div_busy),
      .done     (div_done),
      .quo      (div_quo)
   );

   // signed results and saturating accumulate
   always_comb begin
      mul_s   = mul_neg_ff ? (64'd0 - mul_res) : mul_res;
      quo_s   = div_neg_ff ? (64'd0 - div_quo) : div_quo;
      addend  = cmd.add_quo ? quo_s : term_ff;
      add_ext = {sum_ff[63], sum_ff} + {addend[63], addend};
      sat_pos = !add_ext[64] && add_ext[63];
      sat_neg = add_ext[64] && (!add_ext[63] || (add_ext[62:0] == 63'd0));
   end

   // rounding to the output format, half away from zero
   always_comb begin
      sum_mag = sum_ff[63] ? (64'd0 - sum_ff) : sum_ff;
      rr      = (sum_mag + (64'd1 << (SH - 1))) >> SH;
      if (sum_ff[63]) begin
         clamp = rr > 64'h0000_0000_8000_0000;
      end else begin
         clamp = rr > 64'h0000_0000_7FFF_FFFF;
      end
   end

   // register updates
   always_comb begin
      x_in       = x_ff;
      term_in    = term_ff;
      sum_in     = sum_ff;
      y2_in      = y2_ff;
      k_in       = k_ff;
      ov_in      = ov_ff;
      mul_neg_in = mul_neg_ff;
      div_neg_in = div_neg_ff;
      value_in   = value_ff;
      status_in  = status_ff;
      if (cmd.load) begin
         x_in    = operand;
         term_in = cmd.load_shifted ? ({{32{operand[31]}}, operand} << SH) : ONE_Q32;
         sum_in  = '0;
         k_in    = '0;
         ov_in   = 1'b0;
      end
      if (cmd.mul_start) begin
         mul_neg_in = term_ff[63] ^ mul_bneg;
      end
      if (cmd.mul_wr && mul_done) begin
         if (cmd.mul_to_y2) begin
            y2_in = mul_s;
         end else begin
            term_in = mul_s;
         end
         if (cmd.track_ov && mul_ovf) begin
            ov_in = 1'b1;
         end
         case (cmd.k_step)
            K_INC:   k_in = k_ff + 1'b1;
            K_DEC:   k_in = k_ff - 1'b1;
            default: k_in = k_ff;
         endcase
      end
      if (cmd.div_start) begin
         div_neg_in = dneg;
      end
      if (cmd.div_wr && div_done) begin
         term_in = (div_neg_ff ^ cmd.div_negate) ? (64'd0 - div_quo) : div_quo;
      end
      if (cmd.add_term || cmd.add_quo) begin
         if (sat_pos) begin
            sum_in = IMAX;
         end else if (sat_neg) begin
            sum_in = 64'd0 - IMAX;
         end else begin
            sum_in = add_ext[63:0];
         end
         if (cmd.track_ov && (sat_pos || sat_neg)) begin
            ov_in = 1'b1;
         end
      end
      if (cmd.ln_final) begin
         sum_in = {{(32 - K_W){k_ff[K_W-1]}}, k_ff, 32'd0} + {sum_ff[62:0], 1'b0};
      end
      if (cmd.round) begin
         if (sum_ff[63]) begin
            value_in = clamp ? 32'h8000_0000 : (32'd0 - rr[31:0]);
         end else begin
            value_in = clamp ? 32'h7FFF_FFFF : rr[31:0];
         end
         status_in = (ov_ff || clamp) ? ST_OVERFLOW : ST_OK;
      end
      if (cmd.dom_err) begin
         value_in  = '0;
         status_in = ST_DOMAIN;
      end
   end

   always_ff @(posedge clock) begin
      x_ff       <= x_in;
      term_ff    <= term_in;
      sum_ff     <= sum_in;
      y2_ff      <= y2_in;
      k_ff       <= k_in;
      ov_ff      <= ov_in;
      mul_neg_ff <= mul_neg_in;
      div_neg_ff <= div_neg_in;
      value_ff   <= value_in;
      status_ff  <= status_in;
   end

   // status to the controller
   always_comb begin
      stat.x_nonpos = x_ff[31] || (x_ff == 32'sd0);
      stat.v_above  = term_ff > TWO_Q32;
      stat.v_below  = term_ff < HALF_Q32;
      stat.mul_busy = mul_busy;
      stat.mul_done = mul_done;
      stat.div_busy = div_busy;
      stat.div_done = div_done;
   end

   assign value  = value_ff;
   assign status = status_ff;

endmodule

`default_nettype wire

/* sv/tsfu_ctrl.sv */
// tsfu_ctrl: sequencer for the series evaluation; drives datapath commands
// and the request/response handshakes. Uses tsfu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsfu_ctrl #(
   parameter int MAX_TERMS = tsfu_pkg::MAX_TERMS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   input  wire logic [1:0]                req_opcode,
   output logic                           req_ready,
   input  wire logic                      rsp_ready,
   output logic                           rsp_valid,
   input  wire logic [tsfu_pkg::TC_W-1:0] term_count,
   input  wire tsfu_pkg::dp_stat_type     stat,
   output tsfu_pkg::dp_cmd_type           cmd
);
   import tsfu_pkg::*;

   localparam int N_W = $clog2(MAX_TERMS + 1);

   ctrl_state_type state_ff, state_in;
   opcode_type     op_ff, op_in;
   logic [N_W-1:0] n_ff, n_in, cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free, last_term, is_ln;
   logic [N_W:0]   n2;
   logic [DSR_W-1:0] div_n, div_2n, div_2n_m1, div_2n_p1;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      last_term = ({1'b0, n_ff} + 1'b1) >= {1'b0, cnt_ff};
      is_ln     = op_ff == OP_LN;
      n2        = {n_ff, 1'b0};
      div_n     = DSR_W'(n_ff);
      div_2n    = DSR_W'(n2);
      div_2n_m1 = div_2n - 1'b1;
      div_2n_p1 = div_2n + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      n_ff   <= n_in;
      cnt_ff <= cnt_in;
   end

   // next state and datapath commands
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load         = 1'b1;
               cmd.load_shifted = (req_opcode == OP_LN) || (req_opcode == OP_SIN);
               op_in            = opcode_type'(req_opcode);
               n_in             = '0;
               if (int'(term_count) > MAX_TERMS) begin
                  cnt_in = N_W'(MAX_TERMS);
               end else begin
                  cnt_in = N_W'(term_count);
               end
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            if (is_ln) begin
               state_in = stat.x_nonpos ? S_DOMAIN : S_RED_CHK;
            end else begin
               state_in = (cnt_ff == '0) ? S_ROUND : S_ADD_T;
            end
         end
         // scale into [0.5, 2] by 1/e or e
         S_RED_CHK: begin
            cmd.mul_sh32 = 1'b1;
            if (stat.v_above) begin
               cmd.mul_start = 1'b1;
               cmd.mul_b     = MB_INV_E;
               state_in      = S_RED_DN_WAIT;
            end else if (stat.v_below) begin
               cmd.mul_start = 1'b1;
               cmd.mul_b     = MB_E;
               state_in      = S_RED_UP_WAIT;
            end else begin
               cmd.div_start = 1'b1;
               cmd.div_ln    = 1'b1;
               state_in      = S_LN_DIV_WAIT;
            end
         end
         S_RED_DN_WAIT: begin
            cmd.mul_wr = 1'b1;
            cmd.k_step = K_INC;
            if (stat.mul_done) begin
               state_in = S_RED_CHK;
            end
         end
         S_RED_UP_WAIT: begin
            cmd.mul_wr = 1'b1;
            cmd.k_step = K_DEC;
            if (stat.mul_done) begin
               state_in = S_RED_CHK;
            end
         end
         S_LN_DIV_WAIT: begin
            cmd.div_wr = 1'b1;
            if (stat.div_done) begin
               state_in = S_Y2;
            end
         end
         S_Y2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_b     = MB_TERM;
            cmd.mul_sh32  = 1'b1;
            state_in      = S_Y2_WAIT;
         end
         S_Y2_WAIT: begin
            cmd.mul_wr    = 1'b1;
            cmd.mul_to_y2 = 1'b1;
            if (stat.mul_done) begin
               state_in = (cnt_ff == '0) ? S_LN_FINAL : S_LDIV;
            end
         end
         S_LDIV: begin
            cmd.div_start = 1'b1;
            cmd.divisor   = div_2n_p1;
            state_in      = S_LDIV_WAIT;
         end
         S_LDIV_WAIT: begin
            if (stat.div_done) begin
               state_in = S_ADD_Q;
            end
         end
         S_ADD_Q: begin
            cmd.add_quo = 1'b1;
            state_in    = S_NEXT;
         end
         S_ADD_T: begin
            cmd.add_term = 1'b1;
            cmd.track_ov = 1'b1;
            state_in     = S_NEXT;
         end
         S_NEXT: begin
            if (last_term) begin
               state_in = is_ln ? S_LN_FINAL : S_ROUND;
            end else begin
               n_in     = n_ff + 1'b1;
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            cmd.mul_start = 1'b1;
            cmd.mul_b     = is_ln ? MB_Y2 : MB_X;
            cmd.mul_sh32  = is_ln;
            state_in      = S_MUL1_WAIT;
         end
         S_MUL1_WAIT: begin
            cmd.mul_wr   = 1'b1;
            cmd.track_ov = !is_ln;
            if (stat.mul_done) begin
               state_in = is_ln ? S_LDIV : S_DIV1;
            end
         end
         S_DIV1: begin
            cmd.div_start = 1'b1;
            case (op_ff)
               OP_EXP:  cmd.divisor = div_n;
               OP_SIN:  cmd.divisor = div_2n;
               default: cmd.divisor = div_2n_m1;
            endcase
            state_in = S_DIV1_WAIT;
         end
         S_DIV1_WAIT: begin
            cmd.div_wr = 1'b1;
            if (stat.div_done) begin
               state_in = (op_ff == OP_EXP) ? S_ADD_T : S_MUL2;
            end
         end
         S_MUL2: begin
            cmd.mul_start = 1'b1;
            cmd.mul_b     = MB_X;
            state_in      = S_MUL2_WAIT;
         end
         S_MUL2_WAIT: begin
            cmd.mul_wr   = 1'b1;
            cmd.track_ov = 1'b1;
            if (stat.mul_done) begin
               state_in = S_DIV2;
            end
         end
         S_DIV2: begin
            cmd.div_start = 1'b1;
            cmd.divisor   = (op_ff == OP_SIN) ? div_2n_p1 : div_2n;
            state_in      = S_DIV2_WAIT;
         end
         S_DIV2_WAIT: begin
            cmd.div_wr     = 1'b1;
            cmd.div_negate = 1'b1;
            if (stat.div_done) begin
               state_in = S_ADD_T;
            end
         end
         S_LN_FINAL: begin
            cmd.ln_final = 1'b1;
            state_in     = S_ROUND;
         end
         S_ROUND: begin
            if (out_free) begin
               cmd.round    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_DOMAIN: begin
            if (out_free) begin
               cmd.dom_err  = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;

   // a result word never overwrites one still waiting
   a_out_free: assert property (@(posedge clock) disable iff (reset)
      (cmd.round || cmd.dom_err) |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a pending word");

   // shared units are never restarted while working
   a_mul_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |-> !stat.mul_busy)
      else $error("multiplier started while busy");

   a_div_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.div_start |-> !stat.div_busy)
      else $error("divider started while busy");

   // at most one unit launch or result write per cycle
   a_one_action: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.mul_start, cmd.div_start, cmd.round, cmd.dom_err}))
      else $error("conflicting datapath commands");

   // a started multiply is in flight on the next cycle
   a_mul_runs: assert property (@(posedge clock) disable iff (reset)
      cmd.mul_start |=> stat.mul_busy)
      else $error("multiplier did not start");

endmodule

`default_nettype wire

/* tb/taylor_series_function_unit_test.sv */
// taylor_series_function_unit_test: self-checking bench for the series function unit.
// Needs tsfu_pkg, tsfu_req_if, tsfu_rsp_if and taylor_series_function_unit.
`timescale 1ns / 1ps

module taylor_series_function_unit_test;
   import tsfu_pkg::*;

   localparam longint QMAX      = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam bit [63:0] Q32_ONE = 64'h0000_0001_0000_0000;
   localparam bit [63:0] Q32_E   = 64'h0000_0002_B7E1_5163;
   localparam bit [63:0] Q32_IE  = 64'h0000_0000_5E2D_58D8;
   localparam int CYCLE_LIMIT   = 4_000_000;

   typedef struct packed {
      logic [31:0] value;
      logic [1:0]  status;
   } result_word_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_psel, csr_penable, csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata, csr_prdata;
   logic csr_pready;

   tsfu_req_if req_chan();
   tsfu_rsp_if rsp_chan();

   taylor_series_function_unit dut (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_psel(csr_psel), .csr_penable(csr_penable), .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr), .csr_pwdata(csr_pwdata), .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   // (a*b) >> sh on magnitudes, held at the bound on overflow
   function automatic bit [63:0] mul_shift(bit [63:0] a, bit [63:0] b, int sh,
                                           inout bit ov);
      bit [127:0] p;
      bit [127:0] q;
      p = {64'b0, a} * {64'b0, b};
      if ((p >> (64 + sh - 1)) != 0) begin
         ov = 1'b1;
         return QMAX;
      end
      q = p >> sh;
      return q[63:0];
   endfunction

   function automatic bit [63:0] magnitude(longint a);
      return a < 0 ? -a : a;
   endfunction

   function automatic longint signed_mul(longint a, longint b, int sh, inout bit ov);
      bit neg;
      longint r;
      neg = (a < 0) != (b < 0);
      r = longint'(mul_shift(magnitude(a), magnitude(b), sh, ov));
      return neg ? -r : r;
   endfunction

   function automatic longint sat_add(longint a, longint b, inout bit ov);
      if (b > 0 && a > QMAX - b) begin
         ov = 1'b1;
         return QMAX;
      end
      if (b < 0 && a < -QMAX - b) begin
         ov = 1'b1;
         return -QMAX;
      end
      return a + b;
   endfunction

   // ln in Q32: scale into [0.5, 2], then k + 2 * atanh-style series
   function automatic longint log_sum(longint x, int cnt);
      bit dummy;
      bit [63:0] v, num, den, q, r;
      longint k, sum, p, y2;
      bit yneg;
      dummy = 1'b0;
      k = 0;
      sum = 0;
      v = 64'(x) << 16;
      while (v > 2 * Q32_ONE) begin
         v = mul_shift(v, Q32_IE, 32, dummy);
         k++;
      end
      while (v < Q32_ONE / 2) begin
         v = mul_shift(v, Q32_E, 32, dummy);
         k--;
      end
      yneg = v < Q32_ONE;
      num = yneg ? Q32_ONE - v : v - Q32_ONE;
      den = v + Q32_ONE;
      q = (num << 31) / den;
      r = (num << 31) % den;
      q = 2 * q + ((2 * r >= den) ? 64'd1 : 64'd0);
      p = yneg ? -longint'(q) : longint'(q);
      y2 = signed_mul(p, p, 32, dummy);
      for (int n = 0; n < cnt; n++) begin
         if (n > 0) p = signed_mul(p, y2, 32, dummy);
         sum += p / longint'(2 * n + 1);
      end
      return k * longint'(Q32_ONE) + 2 * sum;
   endfunction

   function automatic result_word_type predict_result(opcode_type op, logic [31:0] raw,
                                                      int terms);
      result_word_type res;
      longint x, sum, t, d, val;
      bit [63:0] m, rr;
      bit ov;
      int cnt;
      cnt = terms > MAX_TERMS_DEF ? MAX_TERMS_DEF : terms;
      x = longint'(signed'(raw));
      ov = 1'b0;
      sum = 0;
      if (op == OP_LN) begin
         if (x <= 0) begin
            res.value = '0;
            res.status = ST_DOMAIN;
            return res;
         end
         sum = log_sum(x, cnt);
      end else begin
         t = (op == OP_SIN) ? x * 65536 : longint'(Q32_ONE);
         for (int n = 0; n < cnt; n++) begin
            if (n > 0) begin
               if (op == OP_EXP) begin
                  t = signed_mul(t, x, 16, ov) / longint'(n);
               end else begin
                  d = (op == OP_SIN) ? longint'(2 * n) : longint'(2 * n - 1);
                  t = signed_mul(t, x, 16, ov) / d;
                  t = signed_mul(t, x, 16, ov) / (d + 1);
                  t = -t;
               end
            end
            sum = sat_add(sum, t, ov);
         end
      end
      // round half away from zero to 16 fraction bits, then clamp
      m = magnitude(sum);
      rr = (m + 64'h8000) >> 16;
      if (sum < 0) begin
         if (rr > 64'h8000_0000) begin
            rr = 64'h8000_0000;
            ov = 1'b1;
         end
         val = -longint'(rr);
      end else begin
         if (rr > 64'h7FFF_FFFF) begin
            rr = 64'h7FFF_FFFF;
            ov = 1'b1;
         end
         val = longint'(rr);
      end
      res.value = val[31:0];
      res.status = ov ? ST_OVERFLOW : ST_OK;
      return res;
   endfunction

   class result_scoreboard;
      result_word_type pending[$];
      int failures = 0;

      function void note_word(opcode_type op, logic [31:0] operand, int terms);
         pending.push_back(predict_result(op, operand, terms));
      endfunction

      function void check_word(logic [31:0] value, logic [1:0] status);
         result_word_type want;
         if (pending.size() == 0) begin
            $error("unexpected result word value=%h status=%0d", value, status);
            failures++;
            return;
         end
         want = pending.pop_front();
         if (value !== want.value) begin
            $error("value: expected %h actual %h", want.value, value);
            failures++;
         end
         if (status !== want.status) begin
            $error("status: expected %0d actual %0d", want.status, status);
            failures++;
         end
      endfunction
   endclass

   result_scoreboard board = new();
   int term_count_now = 25;
   int tx_idle_pct = 0;
   int rx_idle_pct = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   int cycle_count = 0;

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL taylor_series_function_unit");
         $finish;
      end
   end

   // receiver: check accepted words, pick ready for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         if (rsp_chan.valid && rsp_chan.ready)
            board.check_word(rsp_chan.value, rsp_chan.status);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left = 3000;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
         end
      end
   end

   task automatic send_word(opcode_type op, logic [31:0] operand);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.operand <= operand;
      do @(posedge clock); while (!req_chan.ready);
      board.note_word(op, operand, term_count_now);
   endtask

   task automatic write_reg(logic [CSR_ADDR_W-1:0] addr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_pwrite <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      if (addr == 0) term_count_now = data[5:0];
   endtask

   // let the block drain before touching the register
   task automatic drain;
      req_chan.valid <= 1'b0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   function automatic logic [31:0] random_operand(opcode_type op);
      logic [31:0] v;
      case ($urandom_range(0, 9))
         0, 1: v = $urandom;
         2: v = $urandom_range(0, 32'h00FF_FFFF);
         default: v = $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
      // keep most logs in the legal domain
      if (op == OP_LN && $urandom_range(0, 9) != 0) v[31] = 1'b0;
      return v;
   endfunction

   opcode_type dir_op[$] = '{OP_EXP, OP_EXP, OP_EXP, OP_EXP, OP_EXP,
                             OP_LN, OP_LN, OP_LN, OP_LN, OP_LN, OP_LN, OP_LN, OP_LN,
                             OP_SIN, OP_SIN, OP_SIN, OP_SIN,
                             OP_COS, OP_COS, OP_COS, OP_COS};
   logic [31:0] dir_x[$] = '{32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF,
                             32'h8000_0000,
                             32'h0, 32'hFFFF_0000, 32'h0001_0000, 32'h1, 32'h7FFF_FFFF,
                             32'h0000_8000, 32'h0002_0000, 32'h0002_B7E1,
                             32'h0, 32'h0001_921F, 32'h7FFF_FFFF, 32'h8000_0000,
                             32'h0, 32'h0003_243F, 32'h7FFF_FFFF, 32'h8000_0000};
   int phase_terms[9] = '{1, 3, 32, 2, 0, 4, 63, 2, 1};

   // main sequence
   initial begin
      int count;
      opcode_type op;
      reset <= 1'b1;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_EXP;
      req_chan.operand <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed words at the reset term count
      foreach (dir_op[i]) send_word(dir_op[i], dir_x[i]);
      drain();
      // a write to an unmapped index leaves term_count alone; no word is sent before the next write
      write_reg(3'd4, 32'd7);

      foreach (phase_terms[p]) begin
         drain();
         write_reg(3'd0, phase_terms[p]);
         if (p < 3) begin
            tx_idle_pct = 30;
            rx_idle_pct = 82;
         end else if (p < 6) begin
            tx_idle_pct = 82;
            rx_idle_pct = 30;
         end else begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         count = (phase_terms[p] > 8) ? 8 : 205;
         if (p == 7) hold_request = 1'b1;
         for (int i = 0; i < count; i++) begin
            op = opcode_type'($urandom_range(0, 3));
            send_word(op, random_operand(op));
         end
      end

      drain();
      if (board.failures == 0) begin
         $display("PASS taylor_series_function_unit");
      end else begin
         $display("FAIL taylor_series_function_unit");
      end
      $finish;
   end

endmodule
